// File: rtl/ycr_pkg.sv
// Shared types, constants and codes for the YUYV color class run encoder.
package ycr_pkg;

    // Sizing
    localparam int MAX_ROW_WIDTH = 2048;
    localparam int CLASS_COUNT   = 6;
    localparam int MAX_RESULTS   = 3;
    localparam int PUSH_W        = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_AW       = 3;
    localparam int FIFO_DEPTH    = 1 << FIFO_AW;

    // Opcodes and table selects
    localparam logic       OP_PIXEL  = 1'b0;
    localparam logic       OP_TABLE  = 1'b1;
    localparam logic [1:0] SEL_LUMA  = 2'd0;
    localparam logic [1:0] SEL_U     = 2'd1;
    localparam logic [1:0] SEL_V     = 2'd2;

    // Class code for "no color"
    localparam logic [2:0] CLS_NONE  = 3'd0;

    // Configuration register indexes and reset values
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] CFG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RUN_LIMIT    = 2'd2;
    localparam logic [11:0] RST_ROW_WIDTH    = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [22:0] RST_RUN_LIMIT    = 23'd307200;

    // Input request payload
    typedef struct packed {
        logic       opcode;
        logic [7:0] luma_first;
        logic [7:0] chroma_u;
        logic [7:0] luma_second;
        logic [7:0] chroma_v;
        logic [1:0] table_select;
        logic [7:0] table_index;
        logic [7:0] table_entry;
    } t_in_item;

    // Result request payload
    typedef struct packed {
        logic [10:0] run_x;
        logic [10:0] run_y;
        logic [11:0] run_length;
        logic [2:0]  run_class;
        logic [21:0] run_number;
        logic        run_overflow;
        logic        frame_done;
        logic        final_result;
    } t_run_item;

    // Effective geometry and limit seen by the run coder
    typedef struct packed {
        logic [10:0] wm1;    // effective width minus one
        logic [10:0] hm1;    // effective height minus one
        logic [22:0] limit;
    } t_cfg;

    // Table lookups for one pixel pair
    typedef struct packed {
        logic [7:0] y1;
        logic [7:0] y2;
        logic [7:0] u;
        logic [7:0] v;
    } t_lut_rd;

endpackage

// File: rtl/yuyv_color_class_run_encoder_unit.sv
// A pair's lookups are registered, then its runs are written to the queue. One request
// per cycle while not stalled; table lookup and run update take one stage each. Each pair
// gives zero to three runs; runs leave one per cycle, unless the output stalls, from an
// 8-entry queue, and input stalls while the queue cannot hold three more runs per pair in
// flight. Reset (synchronous, active low) clears scan state and queue, loads width 640,
// height 480 and run limit 307200, then a clearing pass zeroes the tables, input stalled.
module yuyv_color_class_run_encoder_unit import ycr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_run_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [22:0]          i_cfg_data
);

    logic [11:0]       r_row_width;
    logic [11:0]       r_frame_height;
    logic [22:0]       r_run_limit;
    logic              r_s1_valid;
    logic              in_req;
    t_cfg              cfg;
    logic [12:0]       eff_w;
    logic [11:0]       eff_h;
    t_lut_rd           lut_rd;
    logic              lut_busy;
    logic [PUSH_W-1:0] push_n;
    t_run_item         items [MAX_RESULTS];
    logic [FIFO_AW:0]  level;

    assign in_req = i_in_valid && !o_in_stall;

    // Stall while tables clear, or unless the queue has room for the pair in the run
    // stage and a new one
    assign o_in_stall = lut_busy ||
                        (({1'b0, level} + (r_s1_valid ? (FIFO_AW + 2)'(MAX_RESULTS) : '0))
                         > (FIFO_AW + 2)'(FIFO_DEPTH - MAX_RESULTS));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= RST_ROW_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_run_limit    <= RST_RUN_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data[11:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[11:0];
                CFG_RUN_LIMIT:    r_run_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective width (even, 2..MAX_ROW_WIDTH) and height (1..2048)
    always_comb begin
        eff_w = {1'b0, r_row_width & 12'hFFE};
        if (eff_w > 13'(MAX_ROW_WIDTH)) eff_w = 13'(MAX_ROW_WIDTH) & ~13'd1;
        if (eff_w > 13'd2048) eff_w = 13'd2048;
        if (eff_w < 13'd2) eff_w = 13'd2;
        eff_h = r_frame_height;
        if (eff_h > 12'd2048) eff_h = 12'd2048;
        if (eff_h < 12'd1) eff_h = 12'd1;
        cfg.wm1   = 11'(eff_w - 13'd1);
        cfg.hm1   = 11'(eff_h - 12'd1);
        cfg.limit = r_run_limit;
    end

    // Run stage holds a pixel pair once its lookups are registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_req && (i_in_item.opcode == OP_PIXEL);
        end
    end

    ycr_class_lut u_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (in_req),
        .i_item  (i_in_item),
        .o_rd    (lut_rd),
        .o_busy  (lut_busy)
    );

    ycr_run_coder u_coder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_rd     (lut_rd),
        .i_cfg    (cfg),
        .o_push_n (push_n),
        .o_items  (items)
    );

    ycr_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_items  (items),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item),
        .o_level  (level)
    );

endmodule

// File: rtl/ycr_class_lut.sv
// Luma, U and V class tables with write port, registered pair lookup and clearing pass.
module ycr_class_lut import ycr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req,
    input  t_in_item i_item,
    output t_lut_rd  o_rd,
    output logic     o_busy
);

    logic [7:0] r_mem_l [256];
    logic [7:0] r_mem_u [256];
    logic [7:0] r_mem_v [256];
    t_lut_rd    r_rd;
    logic [7:0] r_clr_addr;
    logic       r_clr;
    logic       wr;
    logic       rd;

    assign wr = i_req && (i_item.opcode == OP_TABLE);
    assign rd = i_req && (i_item.opcode == OP_PIXEL);

    // Clearing pass after reset: one entry of every table per cycle, all 256 entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 8'd1;
            if (r_clr_addr == 8'd255) r_clr <= 1'b0;
        end
    end

    // Table data writes; the clearing pass zeroes entries first
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem_l[r_clr_addr] <= 8'd0;
            r_mem_u[r_clr_addr] <= 8'd0;
            r_mem_v[r_clr_addr] <= 8'd0;
        end else if (wr) begin
            unique case (i_item.table_select)
                SEL_LUMA: r_mem_l[i_item.table_index] <= i_item.table_entry;
                SEL_U:    r_mem_u[i_item.table_index] <= i_item.table_entry;
                SEL_V:    r_mem_v[i_item.table_index] <= i_item.table_entry;
                default: ;
            endcase
        end
    end

    // Registered reads: luma at two addresses, chroma at one each
    always_ff @(posedge i_clk) begin
        if (rd) begin
            r_rd.y1 <= r_mem_l[i_item.luma_first];
            r_rd.y2 <= r_mem_l[i_item.luma_second];
            r_rd.u  <= r_mem_u[i_item.chroma_u];
            r_rd.v  <= r_mem_v[i_item.chroma_v];
        end
    end

    assign o_rd   = r_rd;
    assign o_busy = r_clr;

endmodule

// File: rtl/ycr_run_coder.sv
// Pixel classification and run tracking; produces up to three runs per pair.
module ycr_run_coder import ycr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_lut_rd           i_rd,
    input  t_cfg              i_cfg,
    output logic [PUSH_W-1:0] o_push_n,
    output t_run_item         o_items [MAX_RESULTS]
);

    typedef struct packed {
        logic [10:0] col;
        logic [10:0] row;
        logic [10:0] start;
        logic [2:0]  cur;
        logic [22:0] re;     // runs counted in this frame
    } t_run_state;

    typedef struct packed {
        t_run_state st;
        logic [1:0] v;       // v[0] class-change run, v[1] row-end run
        t_run_item  e0;
        t_run_item  e1;
    } t_step;

    t_run_state r_st;
    t_step      step1;
    t_step      step2;
    t_run_item  cand [4];
    logic [3:0] cv;
    logic [2:0] cnt;

    // Lowest set class bit among 1..CLASS_COUNT
    function automatic logic [2:0] classify(input logic [7:0] m);
        logic [2:0] c;
        c = CLS_NONE;
        for (int k = CLASS_COUNT; k >= 1; k--) begin
            if (m[k]) c = 3'(k);
        end
        return c;
    endfunction

    // One pixel of the raster scan
    function automatic t_step pix_step(input t_run_state s, input logic [2:0] cls,
                                       input t_cfg cfg);
        t_step r;
        logic  last;
        r      = '0;
        r.st   = s;
        last   = 1'b0;
        if (s.col == 11'd0) begin
            r.st.start = 11'd0;
            r.st.cur   = cls;
        end else if (cls != s.cur) begin
            if (s.cur != CLS_NONE) begin
                r.v[0]          = 1'b1;
                r.e0.run_x      = s.start;
                r.e0.run_y      = s.row;
                r.e0.run_length = {1'b0, s.col} - {1'b0, s.start};
                r.e0.run_class  = s.cur;
                if (r.st.re < cfg.limit) begin
                    r.e0.run_number = r.st.re[21:0];
                    r.st.re         = r.st.re + 23'd1;
                end else begin
                    r.e0.run_overflow = 1'b1;
                end
            end
            r.st.start = s.col;
            r.st.cur   = cls;
        end
        if (s.col >= cfg.wm1) begin
            last            = (s.row >= cfg.hm1);
            r.v[1]          = 1'b1;
            r.e1.run_x      = r.st.start;
            r.e1.run_y      = s.row;
            r.e1.run_length = {1'b0, s.col} + 12'd1 - {1'b0, r.st.start};
            r.e1.run_class  = r.st.cur;
            r.e1.frame_done = last;
            if (r.st.re < cfg.limit) begin
                r.e1.run_number = r.st.re[21:0];
                r.st.re         = r.st.re + 23'd1;
            end else begin
                r.e1.run_overflow = 1'b1;
            end
            r.st.col = 11'd0;
            if (last) begin
                r.st.row = 11'd0;
                r.st.re  = 23'd0;
            end else begin
                r.st.row = s.row + 11'd1;
            end
        end else begin
            r.st.col = s.col + 11'd1;
        end
        return r;
    endfunction

    // Both pixels of the pair, second one sees the state left by the first
    always_comb begin
        step1 = pix_step(r_st, classify(i_rd.y1 & i_rd.u & i_rd.v), i_cfg);
        step2 = pix_step(step1.st, classify(i_rd.y2 & i_rd.u & i_rd.v), i_cfg);
    end

    // Pack emitted runs into consecutive result slots, mark the last
    always_comb begin
        cand[0] = step1.e0;
        cand[1] = step1.e1;
        cand[2] = step2.e0;
        cand[3] = step2.e1;
        cv      = {step2.v[1], step2.v[0], step1.v[1], step1.v[0]};
        cnt     = 3'd0;
        for (int j = 0; j < MAX_RESULTS; j++) o_items[j] = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i]) begin
                if (cnt < 3'(MAX_RESULTS)) o_items[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        for (int j = 0; j < MAX_RESULTS; j++) begin
            o_items[j].final_result = (3'(j) + 3'd1 == cnt);
        end
        o_push_n = i_valid ? PUSH_W'(cnt) : '0;
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_valid) begin
            r_st <= step2.st;
        end
    end

endmodule

// File: rtl/ycr_result_fifo.sv
// Result queue: takes up to three runs a cycle, delivers one a cycle unless stalled.
module ycr_result_fifo import ycr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PUSH_W-1:0]  i_push_n,
    input  t_run_item          i_items [MAX_RESULTS],
    output logic               o_valid,
    input  logic               i_stall,
    output t_run_item          o_item,
    output logic [FIFO_AW:0]   o_level
);

    t_run_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_level = r_count;
    assign n_count = r_count + (FIFO_AW + 1)'(i_push_n) - (FIFO_AW + 1)'(pop);

    // Entry writes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (PUSH_W'(k) < i_push_n) begin
                r_mem[r_wr_ptr + FIFO_AW'(k)] <= i_items[k];
            end
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push_n);
            if (pop) r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            r_count  <= n_count;
        end
    end

endmodule

// File: bench/tb_yuyv_color_class_run_encoder_unit.sv
// Self-checking testbench for the YUYV color class run encoder: predicted runs vs. DUT runs.
`timescale 1ns / 1ps
module tb_yuyv_color_class_run_encoder_unit;
    import ycr_pkg::*;

    localparam logic [1:0] SEL_SKIP    = 2'd3;  // unused select, write is dropped
    localparam int         IDLE_PCT    = 26;
    localparam int         SETTLE      = 6;     // pipeline depth plus margin
    localparam int         STALL_LIMIT = 1000;  // cycles with no request accepted on either side
    localparam int         MAX_REPORTS = 40;

    // DUT connections, all inputs known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_run_item            o_out_item;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [22:0]          i_cfg_data  = '0;

    // Stimulus and expected runs
    t_in_item  pending_req[$];
    t_run_item run_expect[$];
    bit        steady = 1'b0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    // Predictor state
    logic [7:0]  y_tab [256];
    logic [7:0]  u_tab [256];
    logic [7:0]  v_tab [256];
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;
    logic [22:0] cfg_limit;
    int unsigned col_ctr;
    int unsigned row_ctr;
    int unsigned seg_start;
    int unsigned runs_done;
    logic [2:0]  cur_cls;
    bit          ovf_seen;

    // Table indexes that random pixels mostly draw from
    logic [7:0] pal_y [8];
    logic [7:0] pal_u [4];
    logic [7:0] pal_v [4];

    yuyv_color_class_run_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    // AND of the three table entries, lowest class bit wins
    function automatic logic [2:0] pixel_class(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        logic [7:0] m;
        m = y_tab[y] & u_tab[u] & v_tab[v];
        for (int k = 1; k <= CLASS_COUNT && k < 8; k++)
            if (m[k]) return k[2:0];
        return CLS_NONE;
    endfunction

    // Number the run, or flag it once the frame's limit is used up
    task automatic push_run(int unsigned x, int unsigned len, logic [2:0] cls, bit done);
        t_run_item r;
        r = '0;
        r.run_x      = x[10:0];
        r.run_y      = row_ctr[10:0];
        r.run_length = len[11:0];
        r.run_class  = cls;
        r.frame_done = done;
        if (runs_done < cfg_limit) begin
            r.run_number = runs_done[21:0];
            runs_done++;
        end else begin
            r.run_overflow = 1'b1;
            ovf_seen = 1'b1;
        end
        run_expect.push_back(r);
    endtask

    // One pixel of the raster scan
    task automatic advance_pixel(logic [2:0] cls);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        bit last;
        w = 32'(cfg_width & 12'hFFE);
        if (w > MAX_ROW_WIDTH) w = MAX_ROW_WIDTH & ~1;
        if (w > 2048) w = 2048;
        if (w < 2) w = 2;
        h = 32'(cfg_height);
        if (h > 2048) h = 2048;
        if (h < 1) h = 1;
        col = col_ctr;
        if (col == 0) begin
            seg_start = 0;
            cur_cls = cls;
        end else if (cls != cur_cls) begin
            if (cur_cls != CLS_NONE) push_run(seg_start, col - seg_start, cur_cls, 1'b0);
            seg_start = col;
            cur_cls = cls;
        end
        // row end, also when the width shrank under a partial row
        if (col >= w - 1) begin
            last = (row_ctr >= h - 1);
            push_run(seg_start, col + 1 - seg_start, cur_cls, last);
            col_ctr = 0;
            if (last) begin
                row_ctr = 0;
                runs_done = 0;
                ovf_seen = 1'b0;
            end else begin
                row_ctr++;
            end
        end else begin
            col_ctr = col + 1;
        end
    endtask

    task automatic predict_runs(t_in_item it);
        int first;
        logic [2:0] c1;
        logic [2:0] c2;
        t_run_item tail;
        first = run_expect.size();
        if (it.opcode == OP_TABLE) begin
            case (it.table_select)
                SEL_LUMA: y_tab[it.table_index] = it.table_entry;
                SEL_U:    u_tab[it.table_index] = it.table_entry;
                SEL_V:    v_tab[it.table_index] = it.table_entry;
                default:  ;
            endcase
        end else begin
            c1 = pixel_class(it.luma_first, it.chroma_u, it.chroma_v);
            c2 = pixel_class(it.luma_second, it.chroma_u, it.chroma_v);
            advance_pixel(c1);
            advance_pixel(c2);
            if (run_expect.size() > first) begin
                tail = run_expect.pop_back();
                tail.final_result = 1'b1;
                run_expect.push_back(tail);
            end
        end
    endtask

    // ---------------- request builders ----------------

    // Fully random payload so unused fields toggle too
    function automatic t_in_item noise_item();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item pair_item(logic [7:0] y1, logic [7:0] u, logic [7:0] y2,
                                           logic [7:0] v);
        t_in_item it;
        it = noise_item();
        it.opcode      = OP_PIXEL;
        it.luma_first  = y1;
        it.chroma_u    = u;
        it.luma_second = y2;
        it.chroma_v    = v;
        return it;
    endfunction

    function automatic t_in_item table_item(logic [1:0] sel, logic [7:0] idx, logic [7:0] entry);
        t_in_item it;
        it = noise_item();
        it.opcode       = OP_TABLE;
        it.table_select = sel;
        it.table_index  = idx;
        it.table_entry  = entry;
        return it;
    endfunction

    // Mostly palette values so runs form; the rest anywhere in range
    function automatic t_in_item palette_pair();
        logic [7:0] y1;
        logic [7:0] y2;
        logic [7:0] u;
        logic [7:0] v;
        y1 = ($urandom_range(99) < 85) ? pal_y[$urandom_range(7)] : 8'($urandom_range(255));
        y2 = ($urandom_range(99) < 85) ? pal_y[$urandom_range(7)] : 8'($urandom_range(255));
        u  = ($urandom_range(99) < 85) ? pal_u[$urandom_range(3)] : 8'($urandom_range(255));
        v  = ($urandom_range(99) < 85) ? pal_v[$urandom_range(3)] : 8'($urandom_range(255));
        return pair_item(y1, u, y2, v);
    endfunction

    // Pixel pairs with table rewrites sprinkled in, dropped selects included
    function automatic t_in_item mixed_item();
        logic [1:0] sel;
        logic [7:0] idx;
        if ($urandom_range(99) >= 15) return palette_pair();
        sel = 2'($urandom_range(3));
        case (sel)
            SEL_LUMA: idx = pal_y[$urandom_range(7)];
            SEL_U:    idx = pal_u[$urandom_range(3)];
            default:  idx = pal_v[$urandom_range(3)];
        endcase
        if ($urandom_range(3) == 0) idx = 8'($urandom_range(255));
        return table_item(sel, idx, 8'($urandom_range(255)));
    endfunction

    // ---------------- sequencing helpers ----------------

    task automatic queue_mixed(int n, bit pixels_only);
        for (int k = 0; k < n; k++)
            pending_req.push_back(pixels_only ? palette_pair() : mixed_item());
    endtask

    // Sender holds off until every expected run has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_req.size() != 0 || i_in_valid || run_expect.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(logic [11:0] width, logic [11:0] height, logic [22:0] limit);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROW_WIDTH;
        i_cfg_data  <= {11'd0, width};
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= {11'd0, height};
        @(posedge i_clk);
        i_cfg_index <= CFG_RUN_LIMIT;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_width  = width;
        cfg_height = height;
        cfg_limit  = limit;
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_runs(i_in_item);
            // a held request stays put until accepted
            if (!i_in_valid || !o_in_stall) begin
                if (pending_req.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_item  <= pending_req.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_run_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (run_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected run x=%0d y=%0d len=%0d class=%0d",
                        o_out_item.run_x, o_out_item.run_y, o_out_item.run_length,
                        o_out_item.run_class));
                end else begin
                    want = run_expect.pop_front();
                    check_field("run_x", 32'(o_out_item.run_x), 32'(want.run_x));
                    check_field("run_y", 32'(o_out_item.run_y), 32'(want.run_y));
                    check_field("run_length", 32'(o_out_item.run_length),
                                32'(want.run_length));
                    check_field("run_class", 32'(o_out_item.run_class), 32'(want.run_class));
                    check_field("run_number", 32'(o_out_item.run_number),
                                32'(want.run_number));
                    check_field("run_overflow", 32'(o_out_item.run_overflow),
                                32'(want.run_overflow));
                    check_field("frame_done", 32'(o_out_item.frame_done),
                                32'(want.frame_done));
                    check_field("final_result", 32'(o_out_item.final_result),
                                32'(want.final_result));
                end
            end
            i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        for (int k = 0; k < 256; k++) begin
            y_tab[k] = '0;
            u_tab[k] = '0;
            v_tab[k] = '0;
        end
        cfg_width  = RST_ROW_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_limit  = RST_RUN_LIMIT;
        col_ctr    = 0;
        row_ctr    = 0;
        seg_start  = 0;
        runs_done  = 0;
        cur_cls    = CLS_NONE;
        ovf_seen   = 1'b0;
        pal_y[0] = 8'd0;
        pal_y[1] = 8'd1;
        pal_y[2] = 8'd128;
        pal_y[3] = 8'd255;
        for (int k = 4; k < 8; k++) pal_y[k] = 8'($urandom_range(255));
        pal_u[0] = 8'd0;
        pal_u[1] = 8'd255;
        pal_v[0] = 8'd0;
        pal_v[1] = 8'd255;
        for (int k = 2; k < 4; k++) begin
            pal_u[k] = 8'($urandom_range(255));
            pal_v[k] = 8'($urandom_range(255));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset geometry: table extremes, ignored bits, dropped select
        pending_req.push_back(table_item(SEL_LUMA, 8'd0,   8'hFF));
        pending_req.push_back(table_item(SEL_U,    8'd0,   8'hFF));
        pending_req.push_back(table_item(SEL_V,    8'd0,   8'hFF));
        pending_req.push_back(table_item(SEL_LUMA, 8'd255, 8'h81));  // only ignored bits
        pending_req.push_back(table_item(SEL_U,    8'd255, 8'hFF));
        pending_req.push_back(table_item(SEL_V,    8'd255, 8'h7E));
        pending_req.push_back(table_item(SEL_LUMA, 8'd128, 8'h40));  // black only
        pending_req.push_back(table_item(SEL_LUMA, 8'd1,   8'h04));  // white only
        pending_req.push_back(table_item(SEL_SKIP, 8'd0,   8'h00));  // must not clear luma 0
        pending_req.push_back(pair_item(8'd0,   8'd0,   8'd0,   8'd0));
        pending_req.push_back(pair_item(8'd255, 8'd255, 8'd255, 8'd255));
        pending_req.push_back(pair_item(8'd128, 8'd0,   8'd0,   8'd0));
        pending_req.push_back(pair_item(8'd1,   8'd0,   8'd0,   8'd255));
        pending_req.push_back(pair_item(8'd0,   8'd255, 8'd128, 8'd0));
        for (int k = 4; k < 8; k++)
            pending_req.push_back(table_item(SEL_LUMA, pal_y[k], 8'($urandom_range(255))));
        for (int k = 2; k < 4; k++) begin
            pending_req.push_back(table_item(SEL_U, pal_u[k], 8'($urandom_range(255))));
            pending_req.push_back(table_item(SEL_V, pal_v[k], 8'($urandom_range(255))));
        end
        // leave a partial row of the 640-wide frame behind
        queue_mixed(6, 1'b1);
        wait_idle();

        // Odd width under a partial row, short frames, small run limit
        write_config(12'd7, 12'd3, 23'd4);
        queue_mixed(12, 1'b0);
        wait_idle();
        queue_mixed(12, 1'b0);
        wait_idle();

        // Zero width, height and limit: every pair closes a frame, every run flagged
        write_config(12'd0, 12'd0, 23'd0);
        queue_mixed(8, 1'b1);
        wait_idle();

        // Widest row, largest limit, left partial under one long run
        write_config(12'hFFF, 12'd1, 23'h7FFFFF);
        for (int k = 0; k < 8; k++)
            pending_req.push_back(pair_item(8'd0, 8'd0, 8'd0, 8'd0));
        wait_idle();

        // Tallest frame of narrowest rows, limit of one run per frame
        write_config(12'd2, 12'hFFF, 23'd1);
        queue_mixed(10, 1'b1);
        wait_idle();

        // Main random part, first stretch without gaps on either side
        write_config(12'd16, 12'd4, 23'd2048);
        steady <= 1'b1;
        queue_mixed(20, 1'b0);
        wait (pending_req.size() == 0);
        @(posedge i_clk);
        steady <= 1'b0;
        queue_mixed(20, 1'b0);
        wait_idle();

        // Shrink geometry under a partial row and frame
        write_config(12'd4, 12'd1, 23'd3);
        queue_mixed(10, 1'b0);
        wait_idle();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
